// ----- sv/wgen_pkg.sv -----
`default_nettype none
package wgen_pkg;

  localparam int STEP_W      = 32;
  localparam int LEVEL_W     = 13;
  localparam int LEVEL_FULL  = 4096;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int PHASE_BITS_DEFAULT           = 32;
  localparam int SINE_TABLE_ADDR_BITS_DEFAULT = 8;
  localparam int LEVEL_FRAC_BITS_DEFAULT      = 12;

  localparam logic [LEVEL_W-1:0] AMPLITUDE_RESET = 13'd2048;

  // pi/2 in Q30, seed of the quarter-wave series
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_ZERO     = 2'd3
  } wave_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PHASE_STEP    = 3'd0,
    CFG_AMPLITUDE     = 3'd1,
    CFG_OFFSET        = 3'd2,
    CFG_WAVE_MODE     = 3'd3,
    CFG_OUTPUT_ENABLE = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] amplitude;
    logic [LEVEL_W-1:0] offset;
    wave_mode_t         wave_mode;
  } wave_cfg_t;

endpackage
`default_nettype wire

// ----- sv/waveform_generator_core.sv -----
`default_nettype none
// Channel  | Handshake                | Payload
// ---------+--------------------------+----------------------------------
// tick     | tick_valid / tick_ready  | restart
// sample   | sample_valid/sample_ready| level (0..4096)
// config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One tick per cycle sustained while sample_ready stays high; a sample passes
// the queue, table read, multiply, and round and clamp registers in turn.
// Ticks with output disabled are taken in the cycle they arrive and only
// advance the phase. Config writes are always taken (cfg_ready is tied high).
// Reset restores register defaults, clears the phase and empties queue and
// pipeline; the sine table is constant, so there is no clearing pass.
// A stalled sample holds the pipeline; the 2-entry queue absorbs the slack.
module waveform_generator_core #(
  parameter int PHASE_BITS           = wgen_pkg::PHASE_BITS_DEFAULT,
  parameter int SINE_TABLE_ADDR_BITS = wgen_pkg::SINE_TABLE_ADDR_BITS_DEFAULT,
  parameter int LEVEL_FRAC_BITS      = wgen_pkg::LEVEL_FRAC_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             tick_valid,
  output logic                                  tick_ready,
  input  wire logic                             restart,
  output logic                                  sample_valid,
  input  wire logic                             sample_ready,
  output logic [wgen_pkg::LEVEL_W-1:0]          level,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [wgen_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wgen_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wgen_pkg::*;

  // top phase bits needed by the sine address and the triangle slope
  localparam int TAP_W = (SINE_TABLE_ADDR_BITS + 2 > LEVEL_FRAC_BITS)
                         ? SINE_TABLE_ADDR_BITS + 2 : LEVEL_FRAC_BITS;

  logic [STEP_W-1:0]  phase_step;
  logic [LEVEL_W-1:0] amplitude;
  logic [LEVEL_W-1:0] offset;
  wave_mode_t         wave_mode;
  logic               output_enable;
  wave_cfg_t          cfg;

  logic                  q_push_valid;
  logic                  q_push_ready;
  logic [TAP_W-1:0]      q_push_phase;
  logic                  q_pop_valid;
  logic                  q_pop_ready;
  logic [TAP_W-1:0]      q_pop_phase;
  logic [PHASE_BITS-1:0] phase;

  assign cfg_ready = 1'b1;
  assign cfg = '{amplitude: amplitude, offset: offset, wave_mode: wave_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= '0;
      amplitude     <= AMPLITUDE_RESET;
      offset        <= '0;
      wave_mode     <= WAVE_SINE;
      output_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PHASE_STEP:    phase_step    <= cfg_data[STEP_W-1:0];
        CFG_AMPLITUDE:     amplitude     <= cfg_data[LEVEL_W-1:0];
        CFG_OFFSET:        offset        <= cfg_data[LEVEL_W-1:0];
        CFG_WAVE_MODE:     wave_mode     <= wave_mode_t'(cfg_data[1:0]);
        CFG_OUTPUT_ENABLE: output_enable <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  wgen_front #(
    .PHASE_BITS (PHASE_BITS),
    .TAP_W      (TAP_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .tick_valid    (tick_valid),
    .tick_ready    (tick_ready),
    .restart       (restart),
    .phase_step    (phase_step),
    .output_enable (output_enable),
    .push_valid    (q_push_valid),
    .push_ready    (q_push_ready),
    .push_phase    (q_push_phase),
    .phase         (phase)
  );

  wgen_queue #(
    .WIDTH (TAP_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_phase),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_phase)
  );

  wgen_back #(
    .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
    .LEVEL_FRAC_BITS      (LEVEL_FRAC_BITS),
    .TAP_W                (TAP_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pop_valid    (q_pop_valid),
    .pop_ready    (q_pop_ready),
    .pop_phase    (q_pop_phase),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .level        (level)
  );

  a_restart_phase: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready && restart && !cfg_valid)
      |=> (phase == PHASE_BITS'(phase_step)))
    else $error("restart tick did not reload phase from step");

  a_phase_advance: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready && !restart && !cfg_valid)
      |=> (phase == PHASE_BITS'($past(phase) + PHASE_BITS'(phase_step))))
    else $error("phase did not advance by one step");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> (level <= LEVEL_W'(LEVEL_FULL)))
    else $error("level above full scale");

endmodule
`default_nettype wire

// ----- sv/wgen_front.sv -----
`default_nettype none
module wgen_front #(
  parameter int PHASE_BITS = wgen_pkg::PHASE_BITS_DEFAULT,
  parameter int TAP_W      = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        tick_valid,
  output logic                             tick_ready,
  input  wire logic                        restart,
  input  wire logic [wgen_pkg::STEP_W-1:0] phase_step,
  input  wire logic                        output_enable,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output logic [TAP_W-1:0]                 push_phase,
  output logic [PHASE_BITS-1:0]            phase
);
  import wgen_pkg::*;

  logic [PHASE_BITS-1:0] acc;
  logic [PHASE_BITS-1:0] acc_next;
  logic [PHASE_BITS-1:0] cur;
  logic                  take;

  // ticks while disabled are dropped here but still move the phase
  assign tick_ready = !output_enable || push_ready;
  assign take       = tick_valid && tick_ready;
  assign cur        = restart ? '0 : acc;
  assign acc_next   = cur + PHASE_BITS'(phase_step);

  assign push_valid = tick_valid && output_enable;
  assign push_phase = cur[PHASE_BITS-1 -: TAP_W];
  assign phase      = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (take) begin
      acc <= acc_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/wgen_queue.sv -----
`default_nettype none
module wgen_queue #(
  parameter int WIDTH = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);
  import wgen_pkg::*;

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/wgen_back.sv -----
`default_nettype none
module wgen_back #(
  parameter int SINE_TABLE_ADDR_BITS = wgen_pkg::SINE_TABLE_ADDR_BITS_DEFAULT,
  parameter int LEVEL_FRAC_BITS      = wgen_pkg::LEVEL_FRAC_BITS_DEFAULT,
  parameter int TAP_W                = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire wgen_pkg::wave_cfg_t          cfg,
  input  wire logic                         pop_valid,
  output logic                              pop_ready,
  input  wire logic [TAP_W-1:0]             pop_phase,
  output logic                              sample_valid,
  input  wire logic                         sample_ready,
  output logic [wgen_pkg::LEVEL_W-1:0]      level
);
  import wgen_pkg::*;

  localparam int     SINE_N = 1 << SINE_TABLE_ADDR_BITS;
  localparam int     ROM_AW = SINE_TABLE_ADDR_BITS + 1;
  localparam int     X_W    = LEVEL_FRAC_BITS + 2;
  localparam int     PROD_W = LEVEL_W + X_W;
  localparam int     Q_W    = PROD_W - LEVEL_FRAC_BITS;
  localparam int     SUM_W  = LEVEL_W + 3;
  localparam longint ONE_Q  = longint'(1) << LEVEL_FRAC_BITS;
  localparam longint Q30    = longint'(1) << 30;

  typedef logic [LEVEL_FRAC_BITS:0] rom_word_t;
  typedef rom_word_t rom_arr_t [SINE_N+1];

  // round(sin(pi/2*i/N)*one) from an eight-term Taylor series in Q30
  function automatic rom_word_t rom_entry(input int i);
    longint a;
    longint a2;
    longint term;
    longint sum;
    longint v;
    a    = (HALF_PI_Q30 * longint'(i)) / SINE_N;
    a2   = (a * a) / Q30;
    term = a;
    sum  = a;
    // term k divides by (2k)(2k+1)
    term = -((term * a2) / Q30) / 64'sd6;
    sum  = sum + term;
    term = -((term * a2) / Q30) / 64'sd20;
    sum  = sum + term;
    term = -((term * a2) / Q30) / 64'sd42;
    sum  = sum + term;
    term = -((term * a2) / Q30) / 64'sd72;
    sum  = sum + term;
    term = -((term * a2) / Q30) / 64'sd110;
    sum  = sum + term;
    term = -((term * a2) / Q30) / 64'sd156;
    sum  = sum + term;
    term = -((term * a2) / Q30) / 64'sd210;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * ONE_Q + (Q30 / 2)) / Q30;
    if (v > ONE_Q) begin
      v = ONE_Q;
    end
    return rom_word_t'(v);
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    for (int i = 0; i <= SINE_N; i++) begin
      r[i] = rom_entry(i);
    end
    return r;
  endfunction

  localparam rom_arr_t SINE_ROM = build_rom();

  localparam logic [X_W-1:0] ONE_X   = X_W'(ONE_Q);
  localparam logic [X_W-1:0] THREE_X = X_W'(3 * ONE_Q);

  // stage control
  logic v1, v2, v3;
  logic ld1, ld2, ld3;

  // address and non-sine waveforms
  logic [1:0]                    quad;
  logic [SINE_TABLE_ADDR_BITS-1:0] idx;
  logic [ROM_AW-1:0]             rom_addr;
  logic [LEVEL_FRAC_BITS-1:0]    pf;
  logic [X_W-1:0]                pf4;
  logic                          upper_half;
  logic [X_W-1:0]                tri_x;
  logic [X_W-1:0]                alt_x;

  // stage 1
  rom_word_t                     rom_q;
  logic                          neg1;
  logic                          sine1;
  logic [X_W-1:0]                alt1;

  // stage 2
  logic [X_W-1:0]                sine_x;
  logic [X_W-1:0]                x2;
  logic [X_W-1:0]                shifted;
  logic [PROD_W-1:0]             prod;

  // stage 3
  logic [PROD_W:0]               rnd;
  logic [Q_W-1:0]                half_scaled;
  logic [SUM_W-1:0]              lvl_sum;
  logic [LEVEL_W-1:0]            lvl_next;
  logic [LEVEL_W-1:0]            lvl;

  assign ld3       = !v3 || sample_ready;
  assign ld2       = !v2 || ld3;
  assign ld1       = !v1 || ld2;
  assign pop_ready = ld1;

  assign quad       = pop_phase[TAP_W-1 -: 2];
  assign idx        = pop_phase[TAP_W-3 -: SINE_TABLE_ADDR_BITS];
  assign rom_addr   = quad[0] ? (ROM_AW'(SINE_N) - {1'b0, idx}) : {1'b0, idx};
  assign pf         = pop_phase[TAP_W-1 -: LEVEL_FRAC_BITS];
  assign pf4        = {pf, 2'b00};
  assign upper_half = pop_phase[TAP_W-1];
  assign tri_x      = upper_half ? (THREE_X - pf4) : (pf4 - ONE_X);

  always_comb begin
    unique case (cfg.wave_mode)
      WAVE_SQUARE:   alt_x = upper_half ? (X_W'(0) - ONE_X) : ONE_X;
      WAVE_TRIANGLE: alt_x = tri_x;
      default:       alt_x = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      rom_q <= SINE_ROM[rom_addr];
      neg1  <= quad[1];
      sine1 <= (cfg.wave_mode == WAVE_SINE);
      alt1  <= alt_x;
    end
  end

  assign sine_x  = neg1 ? (X_W'(0) - X_W'(rom_q)) : X_W'(rom_q);
  assign x2      = sine1 ? sine_x : alt1;
  // x in [-one, one] moved to [0, 2*one]
  assign shifted = x2 + ONE_X;

  always_ff @(posedge clk) begin
    if (ld2) begin
      prod <= PROD_W'(cfg.amplitude) * PROD_W'(shifted);
    end
  end

  // divide by 2*one with round half up
  assign rnd         = (PROD_W + 1)'(prod) + (PROD_W + 1)'(ONE_Q);
  assign half_scaled = rnd[PROD_W -: Q_W];
  assign lvl_sum     = SUM_W'(cfg.offset) + SUM_W'(half_scaled);
  assign lvl_next    = (lvl_sum > SUM_W'(LEVEL_FULL)) ? LEVEL_W'(LEVEL_FULL)
                                                      : lvl_sum[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (ld3) begin
      lvl <= lvl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= pop_valid;
      end
      if (ld2) begin
        v2 <= v1;
      end
      if (ld3) begin
        v3 <= v2;
      end
    end
  end

  assign sample_valid = v3;
  assign level        = lvl;

endmodule
`default_nettype wire

// ----- tb/sv/waveform_generator_core_tb.sv -----
module waveform_generator_core_tb;
  import wgen_pkg::*;

  localparam int PH = PHASE_BITS_DEFAULT;
  localparam int SA = SINE_TABLE_ADDR_BITS_DEFAULT;
  localparam int FR = LEVEL_FRAC_BITS_DEFAULT;
  localparam int SINE_N = 1 << SA;
  localparam longint ONE_Q = longint'(1) << FR;
  localparam longint Q30 = longint'(1) << 30;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 10;
  localparam int PHASE_TICKS = 50;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   tick_valid;
  logic                   tick_ready;
  logic                   restart;
  logic                   sample_valid;
  logic                   sample_ready;
  logic [LEVEL_W-1:0]     level;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // own copy of the generator state and registers
  bit [PH-1:0]      gen_phase;
  bit [STEP_W-1:0]  gen_step;
  bit [LEVEL_W-1:0] gen_amp;
  bit [LEVEL_W-1:0] gen_off;
  wave_mode_t       gen_mode;
  bit               gen_enable;
  longint           quarter_sine [0:SINE_N];

  logic [LEVEL_W-1:0] pending_levels [$];
  int                 fail_count;
  int                 cycle_count;
  bit                 fast_tx;
  bit                 fast_rx;
  int                 rx_hold;

  waveform_generator_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .restart      (restart),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .level        (level),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("waveform_generator_core_tb failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (fail_count < 50) $display("MISMATCH @%0t: %s", $time, what);
    fail_count++;
  endtask

  // quarter-wave table from the Taylor series in Q30
  task automatic build_sine_table();
    longint a, a2, term, sum, v;
    for (int i = 0; i <= SINE_N; i++) begin
      a = (HALF_PI_Q30 * i) / SINE_N;
      a2 = (a * a) / Q30;
      term = a;
      sum = a;
      for (int k = 1; k <= 7; k++) begin
        term = -((term * a2) / Q30) / ((2 * k) * (2 * k + 1));
        sum += term;
      end
      if (sum < 0) sum = 0;
      v = (sum * ONE_Q + Q30 / 2) / Q30;
      quarter_sine[i] = (v > ONE_Q) ? ONE_Q : v;
    end
  endtask

  function automatic longint wave_value(input bit [PH-1:0] p);
    bit [1:0] quad;
    int       idx;
    longint   s;
    longint   pf;
    case (gen_mode)
      WAVE_SINE: begin
        quad = p[PH-1 -: 2];
        idx = int'((p >> (PH - 2 - SA)) & (SINE_N - 1));
        s = quarter_sine[quad[0] ? SINE_N - idx : idx];
        return quad[1] ? -s : s;
      end
      WAVE_SQUARE: return p[PH-1] ? -ONE_Q : ONE_Q;
      WAVE_TRIANGLE: begin
        pf = longint'(p >> (PH - FR));
        return p[PH-1] ? 3 * ONE_Q - 4 * pf : 4 * pf - ONE_Q;
      end
      default: return 0;
    endcase
  endfunction

  // one tick: clear on restart, sample, then advance
  task automatic advance_tick(input bit rs);
    bit [PH-1:0] p;
    longint      lv;
    if (rs) gen_phase = '0;
    p = gen_phase;
    gen_phase = p + gen_step[PH-1:0];
    if (gen_enable) begin
      lv = longint'(gen_off)
         + (longint'(gen_amp) * (wave_value(p) + ONE_Q) + ONE_Q) / (2 * ONE_Q);
      if (lv < 0) lv = 0;
      if (lv > LEVEL_FULL) lv = LEVEL_FULL;
      pending_levels.push_back(LEVEL_W'(lv));
    end
  endtask

  task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_PHASE_STEP:    gen_step = d[STEP_W-1:0];
      CFG_AMPLITUDE:     gen_amp = d[LEVEL_W-1:0];
      CFG_OFFSET:        gen_off = d[LEVEL_W-1:0];
      CFG_WAVE_MODE:     gen_mode = wave_mode_t'(d[1:0]);
      CFG_OUTPUT_ENABLE: gen_enable = d[0];
      default: ;
    endcase
  endtask

  // sends one tick; valid is left high so back-to-back ticks need no second NBA
  task automatic send_tick(input bit rs);
    int gap;
    gap = fast_tx ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    restart    <= rs;
    do @(posedge clk); while (!tick_ready);
    advance_tick(rs);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
  endtask

  // stop offering ticks, wait for every sample plus pipeline slack
  task automatic drain();
    tick_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input bit [STEP_W-1:0] step, input bit [LEVEL_W-1:0] amp,
                           input bit [LEVEL_W-1:0] off, input wave_mode_t mode, input bit en);
    drain();
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_AMPLITUDE, CFG_DATA_W'(amp));
    write_reg(CFG_OFFSET, CFG_DATA_W'(off));
    write_reg(CFG_WAVE_MODE, CFG_DATA_W'(mode));
    // unmapped index: must have no effect
    write_reg(CFG_INDEX_W'($urandom_range(CFG_OUTPUT_ENABLE + 1, (1 << CFG_INDEX_W) - 1)),
              $urandom);
    write_reg(CFG_OUTPUT_ENABLE, CFG_DATA_W'(en));
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [LEVEL_W-1:0] pick_scale();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return LEVEL_W'(LEVEL_FULL);
      2: return '1;
      3: return LEVEL_W'($urandom_range(LEVEL_FULL + 1, (1 << LEVEL_W) - 1));
      default: return LEVEL_W'($urandom_range(0, LEVEL_FULL));
    endcase
  endfunction

  function automatic bit [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return STEP_W'($urandom_range(1, 1 << 24));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults();
    // disabled after reset: phase moves, nothing comes out
    send_tick(1'b0);
    send_tick(1'b0);
    drain();
    write_reg(CFG_OUTPUT_ENABLE, CFG_DATA_W'(1));
    cfg_valid <= 1'b0;
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_waveform_corners();
    // quarter steps land on every quadrant edge, incl. the table's last entry
    configure(STEP_W'(1) << 30, LEVEL_W'(LEVEL_FULL), '0, WAVE_SINE, 1'b1);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    configure(STEP_W'(1) << 31, LEVEL_W'(LEVEL_FULL), '0, WAVE_SQUARE, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    configure('1, LEVEL_W'(LEVEL_FULL), '0, WAVE_TRIANGLE, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    // amplitude and offset beyond full scale: clamps at the top
    configure('0, '1, '1, WAVE_ZERO, 1'b1);
    send_tick(1'b0);
    configure('0, '0, LEVEL_W'(LEVEL_FULL), WAVE_SQUARE, 1'b1);
    send_tick(1'b0);
    // restart and phase advance while output is off
    configure(STEP_W'(1) << 28, LEVEL_W'(LEVEL_FULL), '0, WAVE_TRIANGLE, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();
    write_reg(CFG_OUTPUT_ENABLE, CFG_DATA_W'(1));
    cfg_valid <= 1'b0;
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  task automatic test_random_phases();
    wave_mode_t mode;
    for (int ph = 0; ph < PHASES; ph++) begin
      mode = (ph < 8) ? wave_mode_t'(ph % 4) : wave_mode_t'($urandom_range(0, 3));
      configure(pick_step(), pick_scale(), pick_scale(), mode, ph != 3);
      fast_tx = (ph == 2) || (ph == 6);
      fast_rx = (ph == 2) || (ph == 5);
      for (int i = 0; i < PHASE_TICKS; i++) send_tick($urandom_range(0, 15) == 0);
      fast_tx = 1'b0;
      fast_rx = 1'b0;
    end
  endtask

  task automatic test_output_stall();
    configure($urandom, LEVEL_W'(LEVEL_FULL), '0, WAVE_SINE, 1'b1);
    rx_hold = 200;
    fast_tx = 1'b1;
    for (int i = 0; i < 30; i++) send_tick(i == 0);
    fast_tx = 1'b0;
  endtask

  // sample receiver: random hold-off per sample, long hold on request
  initial begin
    int wait_n;
    sample_ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      wait_n = fast_rx ? 0 : $urandom_range(0, 9);
      if (rx_hold > 0) begin
        wait_n = rx_hold;
        rx_hold = 0;
      end
      if (wait_n > 0) begin
        sample_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      sample_ready <= 1'b1;
      do @(posedge clk); while (!sample_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && sample_valid === 1'b1 && sample_ready === 1'b1) begin
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected sample transfer, level %0d", level));
      end else begin
        if (level !== pending_levels[0])
          report_mismatch($sformatf("level %0d, expected %0d", level, pending_levels[0]));
        void'(pending_levels.pop_front());
      end
    end
  end

  initial begin
    rst        <= 1'b1;
    tick_valid <= 1'b0;
    restart    <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    fail_count = 0;
    cycle_count = 0;
    fast_tx = 1'b0;
    fast_rx = 1'b0;
    rx_hold = 0;
    gen_phase = '0;
    gen_step = '0;
    gen_amp = AMPLITUDE_RESET;
    gen_off = '0;
    gen_mode = WAVE_SINE;
    gen_enable = 1'b0;
    build_sine_table();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_waveform_corners();
    test_random_phases();
    test_output_stall();
    drain();

    if (fail_count == 0) begin
      $display("waveform_generator_core_tb passed");
    end else begin
      $display("waveform_generator_core_tb failed");
    end
    $finish;
  end

endmodule
